### sv/llsc_pkg.sv
// shared types, constants and arithmetic helpers of the linear logistic scorer
`default_nettype none

package llsc_pkg;

    // item kinds carried on tuser
    localparam logic [1:0] KIND_WIN_LOAD    = 2'd0;
    localparam logic [1:0] KIND_SPREAD_LOAD = 2'd1;
    localparam logic [1:0] KIND_FEATURE     = 2'd2;

    // field widths of the stream beats
    localparam int unsigned POS_W   = 4;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned PROB_W  = 16;
    localparam int unsigned IN_DW   = 40;
    localparam int unsigned OUT_DW  = 48;

    // widest coefficient address, enough for sixty-four weights plus the bias
    localparam int unsigned COEF_AW = 7;

    // Q0.30 unity for the sigmoid knot build
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // sigmoid table span in Q32.32: [-8, 8)
    localparam logic signed [63:0] LOGIT_LO = 64'shFFFF_FFF8_0000_0000;
    localparam logic signed [63:0] LOGIT_HI = 64'sh0000_0008_0000_0000;

    // coefficient store write port
    typedef struct packed {
        logic                  win_en;
        logic                  spread_en;
        logic [COEF_AW-1:0]    addr;
        logic [VALUE_W-1:0]    data;
    } llsc_coef_wr_t;

    // coefficient store read port
    typedef struct packed {
        logic                  en;
        logic [COEF_AW-1:0]    addr;
    } llsc_coef_rd_t;

    // signed 64-bit add clamped to the 64-bit limits
    function automatic logic signed [63:0] sat_add64(
        input logic signed [63:0] a,
        input logic signed [63:0] b
    );
        logic signed [64:0] sum;
        sum = {a[63], a} + {b[63], b};
        if (sum[64] != sum[63])
        begin
            sat_add64 = sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            sat_add64 = sum[63:0];
        end
    endfunction

endpackage

`default_nettype wire

### sv/linear_logistic_scorer.sv
// Load beats, reserved beats and non-last features past the weights leave input ready.
// A contributing feature beat passes the coefficient memory read, then the multiply
// state with input not ready, the accumulation overlapping the next beat.
// A last feature runs the multiply, last-accumulate, bias and sigmoid states; its result
// and input ready return together; a result stalled on the output delays both until taken.
// Reset clears accumulators, written flags and output valid; unwritten coefficients read zero.
`default_nettype none

module linear_logistic_scorer
    import llsc_pkg::*;
#(
    parameter int unsigned FEATURE_COUNT    = 12,
    parameter int unsigned SIGMOID_SEGMENTS = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DW-1:0]     s_tdata,   // position[3:0], value[35:4], zero pad
    input  wire logic [1:0]           s_tuser,   // kind[1:0]
    input  wire logic                 s_tlast,   // last feature of the vector
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_DW-1:0]         m_tdata    // win_probability[15:0],
                                                 // predicted_spread[47:16]
);

    localparam int unsigned        ROM_AW = $clog2(SIGMOID_SEGMENTS + 1);
    localparam int unsigned        P_W    = 36 + ROM_AW;
    localparam logic [COEF_AW-1:0] NF_L   = COEF_AW'(FEATURE_COUNT);
    localparam logic [ROM_AW-1:0]  SEG_L  = ROM_AW'(SIGMOID_SEGMENTS);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_LACC = 3'd2;
    localparam logic [2:0] ST_BIAS = 3'd3;
    localparam logic [2:0] ST_SIG1 = 3'd4;
    localparam logic [2:0] ST_SIG2 = 3'd5;
    localparam logic [2:0] ST_SIG3 = 3'd6;
    localparam logic [2:0] ST_SIG4 = 3'd7;

    logic [2:0]                state_reg,    state_next;
    logic                      acc_pend_reg, acc_pend_next;
    logic signed [63:0]        acc_w_reg,    acc_w_next;
    logic signed [63:0]        acc_s_reg,    acc_s_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    logic signed [VALUE_W-1:0] value_reg,    value_next;
    logic                      contrib_reg,  contrib_next;
    logic                      last_reg,     last_next;
    logic signed [63:0]        prod_w_reg,   prod_w_next;
    logic signed [63:0]        prod_s_reg,   prod_s_next;
    logic signed [63:0]        logit_w_reg,  logit_w_next;
    logic signed [63:0]        logit_s_reg,  logit_s_next;
    logic [P_W-1:0]            p_reg,        p_next;
    logic                      lt_reg,       lt_next;
    logic                      ge_reg,       ge_next;
    logic [VALUE_W-1:0]        spread_reg,   spread_next;
    logic [15:0]               f_reg,        f_next;
    logic [32:0]               ip_a_reg,     ip_a_next;
    logic [31:0]               ip_b_reg,     ip_b_next;
    logic [OUT_DW-1:0]         m_tdata_reg,  m_tdata_next;

    logic [1:0]                kind_in;
    logic [POS_W-1:0]          pos_in;
    logic signed [VALUE_W-1:0] value_in;
    logic [COEF_AW-1:0]        pos_ext;
    logic                      accept;

    llsc_coef_wr_t             coef_wr;
    llsc_coef_rd_t             coef_rd;
    logic signed [VALUE_W-1:0] win_coef;
    logic signed [VALUE_W-1:0] spread_coef;
    logic signed [63:0]        mul_w;
    logic signed [63:0]        mul_s;

    logic                      rom_rd_en;
    logic [ROM_AW-1:0]         rom_addr_a;
    logic [ROM_AW-1:0]         rom_addr_b;
    logic [PROB_W-1:0]         rom_data_a;
    logic [PROB_W-1:0]         rom_data_b;

    logic [35:0]               u_off;
    logic [ROM_AW-1:0]         seg_idx;
    logic [33:0]               ip_sum;

    // beat unpacking
    assign kind_in  = s_tuser;
    assign pos_in   = s_tdata[POS_W-1:0];
    assign value_in = $signed(s_tdata[POS_W +: VALUE_W]);
    assign pos_ext  = {{(COEF_AW - POS_W){1'b0}}, pos_in};
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // coefficient loads go straight to memory
    assign coef_wr.win_en    = accept && (kind_in == KIND_WIN_LOAD) && (pos_ext <= NF_L);
    assign coef_wr.spread_en = accept && (kind_in == KIND_SPREAD_LOAD) && (pos_ext <= NF_L);
    assign coef_wr.addr      = pos_ext;
    assign coef_wr.data      = value_in;

    // weight read on feature accept, bias read while multiplying a last feature
    assign coef_rd.en   = (accept && (kind_in == KIND_FEATURE) && (pos_ext < NF_L))
                       || ((state_reg == ST_MUL) && last_reg);
    assign coef_rd.addr = (state_reg == ST_MUL) ? NF_L : pos_ext;

    llsc_coef_store #(
        .DEPTH (FEATURE_COUNT + 1)
    ) u_coef (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (coef_wr),
        .rd          (coef_rd),
        .win_coef    (win_coef),
        .spread_coef (spread_coef)
    );

    // full Q32.32 products of weight and feature
    assign mul_w = win_coef * value_reg;
    assign mul_s = spread_coef * value_reg;

    // table position: logit + 8 is the logit with bit 35 flipped inside the span
    assign u_off   = {~logit_w_reg[35], logit_w_reg[34:0]};
    assign seg_idx = p_reg[P_W-1:36];

    assign rom_rd_en  = (state_reg == ST_SIG2);
    assign rom_addr_a = lt_reg ? '0 : (ge_reg ? SEG_L : seg_idx);
    assign rom_addr_b = lt_reg ? '0 : (ge_reg ? SEG_L : ROM_AW'(seg_idx + 1'b1));

    llsc_sig_rom #(
        .SEGMENTS (SIGMOID_SEGMENTS),
        .AW       (ROM_AW)
    ) u_rom (
        .clk    (clk),
        .rd_en  (rom_rd_en),
        .addr_a (rom_addr_a),
        .addr_b (rom_addr_b),
        .data_a (rom_data_a),
        .data_b (rom_data_b)
    );

    assign ip_sum = {1'b0, ip_a_reg} + {2'b00, ip_b_reg};

    // sequencer and datapath
    always_comb
    begin
        state_next    = state_reg;
        acc_pend_next = acc_pend_reg;
        acc_w_next    = acc_w_reg;
        acc_s_next    = acc_s_reg;
        m_tvalid_next = m_tvalid_reg;
        value_next    = value_reg;
        contrib_next  = contrib_reg;
        last_next     = last_reg;
        prod_w_next   = prod_w_reg;
        prod_s_next   = prod_s_reg;
        logit_w_next  = logit_w_reg;
        logit_s_next  = logit_s_reg;
        p_next        = p_reg;
        lt_next       = lt_reg;
        ge_next       = ge_reg;
        spread_next   = spread_reg;
        f_next        = f_reg;
        ip_a_next     = ip_a_reg;
        ip_b_next     = ip_b_reg;
        m_tdata_next  = m_tdata_reg;

        // output beat taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // fold in the product of the previous feature
                if (acc_pend_reg)
                begin
                    acc_w_next    = sat_add64(acc_w_reg, prod_w_reg);
                    acc_s_next    = sat_add64(acc_s_reg, prod_s_reg);
                    acc_pend_next = 1'b0;
                end
                if (accept && (kind_in == KIND_FEATURE))
                begin
                    value_next   = value_in;
                    contrib_next = (pos_ext < NF_L);
                    last_next    = s_tlast;
                    if ((pos_ext < NF_L) || s_tlast)
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_w_next = contrib_reg ? mul_w : '0;
                prod_s_next = contrib_reg ? mul_s : '0;
                if (last_reg)
                begin
                    state_next = ST_LACC;
                end
                else
                begin
                    acc_pend_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_LACC:
            begin
                acc_w_next = sat_add64(acc_w_reg, prod_w_reg);
                acc_s_next = sat_add64(acc_s_reg, prod_s_reg);
                state_next = ST_BIAS;
            end
            ST_BIAS:
            begin
                // bias in Q16.16 lifted to Q32.32, accumulators restart
                logit_w_next = sat_add64(acc_w_reg,
                                         {{16{win_coef[31]}}, win_coef, 16'h0000});
                logit_s_next = sat_add64(acc_s_reg,
                                         {{16{spread_coef[31]}}, spread_coef, 16'h0000});
                acc_w_next   = '0;
                acc_s_next   = '0;
                state_next   = ST_SIG1;
            end
            ST_SIG1:
            begin
                lt_next = (logit_w_reg < LOGIT_LO);
                ge_next = (logit_w_reg >= LOGIT_HI);
                p_next  = P_W'(u_off) * P_W'(SIGMOID_SEGMENTS);
                // spread floored to Q16.16 and clamped
                if (logit_s_reg[63:47] == {17{logit_s_reg[63]}})
                begin
                    spread_next = logit_s_reg[47:16];
                end
                else
                begin
                    spread_next = logit_s_reg[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                state_next = ST_SIG2;
            end
            ST_SIG2:
            begin
                f_next     = (lt_reg || ge_reg) ? 16'h0000 : p_reg[35:20];
                state_next = ST_SIG3;
            end
            ST_SIG3:
            begin
                ip_a_next  = 33'(rom_data_a) * (33'h1_0000 - 33'(f_reg));
                ip_b_next  = 32'(rom_data_b) * 32'(f_reg);
                state_next = ST_SIG4;
            end
            ST_SIG4:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next  = {spread_reg, ip_sum[31:16]};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            acc_pend_reg <= 1'b0;
            acc_w_reg    <= '0;
            acc_s_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            acc_pend_reg <= acc_pend_next;
            acc_w_reg    <= acc_w_next;
            acc_s_reg    <= acc_s_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        contrib_reg <= contrib_next;
        last_reg    <= last_next;
        prod_w_reg  <= prod_w_next;
        prod_s_reg  <= prod_s_next;
        logit_w_reg <= logit_w_next;
        logit_s_reg <= logit_s_next;
        p_reg       <= p_next;
        lt_reg      <= lt_next;
        ge_reg      <= ge_next;
        spread_reg  <= spread_next;
        f_reg       <= f_next;
        ip_a_reg    <= ip_a_next;
        ip_b_reg    <= ip_b_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

### sv/llsc_coef_store.sv
// win and spread coefficient memories with per-entry valid flags
`default_nettype none

module llsc_coef_store
    import llsc_pkg::*;
#(
    parameter int unsigned DEPTH = 13
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire llsc_coef_wr_t              wr,
    input  wire llsc_coef_rd_t              rd,
    output logic signed [VALUE_W-1:0]       win_coef,
    output logic signed [VALUE_W-1:0]       spread_coef
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VALUE_W-1:0] win_mem    [0:DEPTH-1];
    logic [VALUE_W-1:0] spread_mem [0:DEPTH-1];

    logic [DEPTH-1:0]   win_vld_reg;
    logic [DEPTH-1:0]   spread_vld_reg;
    logic               win_rd_vld_reg;
    logic               spread_rd_vld_reg;
    logic [VALUE_W-1:0] win_rd_reg;
    logic [VALUE_W-1:0] spread_rd_reg;

    logic [IDX_W-1:0]   wr_idx;
    logic [IDX_W-1:0]   rd_idx;

    assign wr_idx = wr.addr[IDX_W-1:0];
    assign rd_idx = rd.addr[IDX_W-1:0];

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.win_en)
        begin
            win_mem[wr_idx] <= wr.data;
        end
        if (wr.spread_en)
        begin
            spread_mem[wr_idx] <= wr.data;
        end
        if (rd.en)
        begin
            win_rd_reg    <= win_mem[rd_idx];
            spread_rd_reg <= spread_mem[rd_idx];
        end
    end

    // written flags, an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_vld_reg       <= '0;
            spread_vld_reg    <= '0;
            win_rd_vld_reg    <= 1'b0;
            spread_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.win_en)
            begin
                win_vld_reg[wr_idx] <= 1'b1;
            end
            if (wr.spread_en)
            begin
                spread_vld_reg[wr_idx] <= 1'b1;
            end
            if (rd.en)
            begin
                win_rd_vld_reg    <= win_vld_reg[rd_idx];
                spread_rd_vld_reg <= spread_vld_reg[rd_idx];
            end
        end
    end

    assign win_coef    = win_rd_vld_reg    ? $signed(win_rd_reg)    : '0;
    assign spread_coef = spread_rd_vld_reg ? $signed(spread_rd_reg) : '0;

endmodule

`default_nettype wire

### sv/llsc_sig_rom.sv
// sigmoid knot table with two registered read ports
`default_nettype none

module llsc_sig_rom
    import llsc_pkg::*;
#(
    parameter int unsigned SEGMENTS = 64,
    parameter int unsigned AW       = 7
)
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     addr_a,
    input  wire logic [AW-1:0]     addr_b,
    output logic [PROB_W-1:0]      data_a,
    output logic [PROB_W-1:0]      data_b
);

    localparam logic [63:0] SEG64 = 64'(SEGMENTS);

    logic [PROB_W-1:0] rom [0:SEGMENTS];
    logic [PROB_W-1:0] data_a_reg;
    logic [PROB_W-1:0] data_b_reg;

    // knot k sits at x = -8 + 16k/SEGMENTS, worked out at elaboration
    for (genvar k = 0; k <= SEGMENTS; k = k + 1)
    begin : g_knot
        localparam logic [63:0] K2   = 64'(2 * k);
        localparam logic [63:0] SPAN = (K2 >= SEG64) ? (K2 - SEG64) : (SEG64 - K2);
        // |x|/16 in Q0.30
        localparam logic [63:0] TT   = (SPAN << 29) / SEG64;
        // truncated series for e^-t
        localparam logic [63:0] E1  = ((Q30_ONE * TT) >> 30) / 64'd1;
        localparam logic [63:0] E2  = ((E1 * TT) >> 30) / 64'd2;
        localparam logic [63:0] E3  = ((E2 * TT) >> 30) / 64'd3;
        localparam logic [63:0] E4  = ((E3 * TT) >> 30) / 64'd4;
        localparam logic [63:0] E5  = ((E4 * TT) >> 30) / 64'd5;
        localparam logic [63:0] E6  = ((E5 * TT) >> 30) / 64'd6;
        localparam logic [63:0] E7  = ((E6 * TT) >> 30) / 64'd7;
        localparam logic [63:0] E8  = ((E7 * TT) >> 30) / 64'd8;
        localparam logic [63:0] E9  = ((E8 * TT) >> 30) / 64'd9;
        localparam logic [63:0] E10 = ((E9 * TT) >> 30) / 64'd10;
        localparam logic [63:0] E11 = ((E10 * TT) >> 30) / 64'd11;
        localparam logic [63:0] E12 = ((E11 * TT) >> 30) / 64'd12;
        localparam logic [63:0] POS_SUM = Q30_ONE + E2 + E4 + E6 + E8 + E10 + E12;
        localparam logic [63:0] NEG_SUM = E1 + E3 + E5 + E7 + E9 + E11;
        localparam logic [63:0] R0 = (POS_SUM > NEG_SUM) ? (POS_SUM - NEG_SUM) : 64'd0;
        // four squarings raise e^-(|x|/16) to e^-|x|
        localparam logic [63:0] R1 = (R0 * R0 + (Q30_ONE >> 1)) >> 30;
        localparam logic [63:0] R2 = (R1 * R1 + (Q30_ONE >> 1)) >> 30;
        localparam logic [63:0] R3 = (R2 * R2 + (Q30_ONE >> 1)) >> 30;
        localparam logic [63:0] R4 = (R3 * R3 + (Q30_ONE >> 1)) >> 30;
        localparam logic [63:0] DEN  = Q30_ONE + R4;
        localparam logic [63:0] NUMR = (K2 < SEG64) ? R4 : Q30_ONE;
        localparam logic [63:0] VAL  = (NUMR * 64'd65536 + DEN / 64'd2) / DEN;
        localparam logic [63:0] KNOT = (VAL > 64'd65535) ? 64'd65535 : VAL;

        assign rom[k] = KNOT[PROB_W-1:0];
    end

    // registered reads of both neighbouring knots
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_a_reg <= rom[addr_a];
            data_b_reg <= rom[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

`default_nettype wire

### sv/llsc_checker.sv
// port-level checks of the linear logistic scorer and their binding
`default_nettype none

module llsc_checker
    import llsc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [1:0]        s_tuser,
    input  wire logic              s_tlast,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [OUT_DW-1:0] m_tdata
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // input stays ready after a coefficient load
    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready
        && (s_tuser == KIND_WIN_LOAD || s_tuser == KIND_SPREAD_LOAD) |=> s_tready)
        else $error("input stalled after a coefficient load");

    // a closing feature holds off the input while the result is formed
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == KIND_FEATURE && s_tlast |=> !s_tready)
        else $error("input ready straight after a last feature");

    // a new result only leaves the sigmoid stages, never the idle state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while input was ready");

endmodule

bind linear_logistic_scorer llsc_checker u_llsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### test/llsc_score_checker.sv
// score checker for the linear logistic scorer: tracks both sums and compares each score beat
`timescale 1ns / 1ps

module llsc_score_checker
    import llsc_pkg::*;
#(
    parameter int unsigned FEATURE_COUNT    = 12,
    parameter int unsigned SIGMOID_SEGMENTS = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [IN_DW-1:0]  s_tdata,   // position[3:0], value[35:4], zero pad
    input  wire logic [1:0]        s_tuser,   // kind[1:0]
    input  wire logic              s_tlast,   // last feature of the vector
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [OUT_DW-1:0] m_tdata,   // win_probability[15:0],
                                              // predicted_spread[47:16]
    output int                     failures,
    output int                     pending
);

    localparam longint SUM_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SUM_MIN    = 64'sh8000_0000_0000_0000;
    localparam longint SPREAD_MAX = 64'sd2147483647;
    localparam longint SPREAD_MIN = -64'sd2147483648;

    typedef struct {
        logic [PROB_W-1:0]  prob;
        logic [VALUE_W-1:0] spread;
    } score_t;

    logic signed [VALUE_W-1:0] win_coef    [0:FEATURE_COUNT] = '{default: '0};
    logic signed [VALUE_W-1:0] spread_coef [0:FEATURE_COUNT] = '{default: '0};
    longint                    win_sum    = 0;
    longint                    spread_sum = 0;
    longint unsigned           knots [0:SIGMOID_SEGMENTS];
    score_t                    expected_scores [$];
    int                        mismatches = 0;

    // sigmoid knots at -8 + 16k/S, built the same way the hardware table is defined
    initial
    begin
        longint unsigned span, t, term, r, den, num, v;
        longint          series;
        for (int k = 0; k <= SIGMOID_SEGMENTS; k++)
        begin
            span = (2 * k >= SIGMOID_SEGMENTS) ? 2 * k - SIGMOID_SEGMENTS
                                               : SIGMOID_SEGMENTS - 2 * k;
            t = (span << 29) / SIGMOID_SEGMENTS;
            // floored taylor terms of e^-t, t being |x|/16
            series = Q30_ONE;
            term   = Q30_ONE;
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * t) >> 30) / n;
                if (n % 2 == 1)
                    series -= longint'(term);
                else
                    series += longint'(term);
            end
            r = (series > 0) ? series : 0;
            // four rounded squarings raise it to the sixteenth power
            for (int n = 0; n < 4; n++)
                r = (r * r + (Q30_ONE >> 1)) >> 30;
            den = Q30_ONE + r;
            num = (2 * k < SIGMOID_SEGMENTS) ? r : Q30_ONE;
            v = (num * 65536 + den / 2) / den;
            knots[k] = (v > 65535) ? 65535 : v;
        end
    end

    // signed 64-bit sum held at the limits on overflow
    function automatic longint clamp_add(input longint a, input longint b);
        longint total;
        total = a + b;
        if (a[63] == b[63] && total[63] != a[63])
            return a[63] ? SUM_MIN : SUM_MAX;
        return total;
    endfunction

    // interpolated sigmoid of a Q32.32 logit
    function automatic logic [PROB_W-1:0] logistic_of(input longint logit);
        longint unsigned p, seg, frac;
        if (logit < LOGIT_LO)
            return PROB_W'(knots[0]);
        if (logit >= LOGIT_HI)
            return PROB_W'(knots[SIGMOID_SEGMENTS]);
        p    = longint'(logit - LOGIT_LO) * SIGMOID_SEGMENTS;
        seg  = p >> 36;
        frac = (p & ((64'd1 << 36) - 1)) >> 20;
        if (seg >= SIGMOID_SEGMENTS)
            return PROB_W'(knots[SIGMOID_SEGMENTS]);
        return PROB_W'((knots[seg] * (65536 - frac) + knots[seg + 1] * frac) >> 16);
    endfunction

    // Q32.32 floored to Q16.16, clamped to 32 bits
    function automatic logic [VALUE_W-1:0] spread_q16(input longint acc);
        longint q;
        q = acc >>> 16;
        if (q > SPREAD_MAX)
            q = SPREAD_MAX;
        else if (q < SPREAD_MIN)
            q = SPREAD_MIN;
        return q[VALUE_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] score mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [POS_W-1:0]          pos;
        logic signed [VALUE_W-1:0] val;
        score_t                    due;
        if (!rst_n)
        begin
            for (int i = 0; i <= FEATURE_COUNT; i++)
            begin
                win_coef[i]    = '0;
                spread_coef[i] = '0;
            end
            win_sum    = 0;
            spread_sum = 0;
            expected_scores.delete();
        end
        else
        begin
            // input beat: coefficient write or multiply-accumulate
            if (s_tvalid && s_tready)
            begin
                pos = s_tdata[POS_W-1:0];
                val = s_tdata[POS_W +: VALUE_W];
                if (s_tuser == KIND_WIN_LOAD || s_tuser == KIND_SPREAD_LOAD)
                begin
                    if (pos <= FEATURE_COUNT)
                    begin
                        if (s_tuser == KIND_WIN_LOAD)
                            win_coef[pos] = val;
                        else
                            spread_coef[pos] = val;
                    end
                end
                else if (s_tuser == KIND_FEATURE)
                begin
                    if (pos < FEATURE_COUNT)
                    begin
                        win_sum    = clamp_add(win_sum, longint'(win_coef[pos]) * longint'(val));
                        spread_sum = clamp_add(spread_sum,
                                               longint'(spread_coef[pos]) * longint'(val));
                    end
                    // last feature: add biases and queue the score
                    if (s_tlast)
                    begin
                        due.prob   = logistic_of(clamp_add(win_sum,
                                         longint'(win_coef[FEATURE_COUNT]) * 65536));
                        due.spread = spread_q16(clamp_add(spread_sum,
                                         longint'(spread_coef[FEATURE_COUNT]) * 65536));
                        expected_scores.push_back(due);
                        win_sum    = 0;
                        spread_sum = 0;
                    end
                end
            end
            // output beat against the oldest queued score
            if (m_tvalid && m_tready)
            begin
                if (expected_scores.size() == 0)
                begin
                    report_mismatch($sformatf("score beat %h with none expected", m_tdata));
                end
                else
                begin
                    due = expected_scores.pop_front();
                    if (m_tdata[PROB_W-1:0] !== due.prob)
                        report_mismatch($sformatf("win_probability %h, expected %h",
                                                  m_tdata[PROB_W-1:0], due.prob));
                    if (m_tdata[PROB_W +: VALUE_W] !== due.spread)
                        report_mismatch($sformatf("predicted_spread %h, expected %h",
                                                  m_tdata[PROB_W +: VALUE_W], due.spread));
                end
            end
        end
        failures <= mismatches;
        pending  <= expected_scores.size();
    end

endmodule

### test/tb.sv
// stimulus, handshake pacing and verdict for the linear logistic scorer
`timescale 1ns / 1ps

module tb;

    import llsc_pkg::*;

    localparam int unsigned FEATURES     = 12;
    localparam int unsigned SEGMENTS     = 64;
    localparam logic [1:0]  KIND_RESERVED = 2'd3;
    localparam int          RANDOM_ITEMS = 1100;
    localparam int          TAIL_ITEMS   = 150;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 20;

    // Q16.16 values used by the directed beats
    localparam logic [VALUE_W-1:0] Q16_ONE     = 32'h0001_0000;
    localparam logic [VALUE_W-1:0] Q16_MAX     = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] Q16_MIN     = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] PLUS_EIGHT  = 32'h0008_0000;
    localparam logic [VALUE_W-1:0] MINUS_EIGHT = 32'hFFF8_0000;

    // bias position as a beat field
    localparam logic [POS_W-1:0]   BIAS_POS    = POS_W'(FEATURES);

    logic              clk;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_DW-1:0]  s_tdata  = '0;
    logic [1:0]        s_tuser  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_DW-1:0] m_tdata;
    int                failures;
    int                pending;

    bit tail_phase   = 1'b0;
    bit gaps_on      = 1'b1;
    int useful_items = 0;

    linear_logistic_scorer #(
        .FEATURE_COUNT    (FEATURES),
        .SIGMOID_SEGMENTS (SEGMENTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    llsc_score_checker #(
        .FEATURE_COUNT    (FEATURES),
        .SIGMOID_SEGMENTS (SEGMENTS)
    ) score_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // one input beat, with an occasional gap before it
    task automatic push_item(input logic [1:0] kind, input logic [POS_W-1:0] pos,
                             input logic [VALUE_W-1:0] value, input logic last);
        if (!tail_phase && gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(IN_DW - POS_W - VALUE_W){1'b0}}, value, pos};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        if (kind == KIND_FEATURE
            || ((kind == KIND_WIN_LOAD || kind == KIND_SPREAD_LOAD) && pos <= FEATURES))
            useful_items++;
    endtask

    // stop sending until every queued score has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // mostly values near unity so logits fall inside the table, with corners and noise
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 5))
                    0:       return Q16_MAX;
                    1:       return Q16_MIN;
                    2:       return '0;
                    3:       return '1;
                    4:       return Q16_ONE;
                    default: return -Q16_ONE;
                endcase
            end
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    // receiver back-pressure in bursts, with calm stretches
    initial
    begin
        int hold;
        bit calm;
        hold = 0;
        calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (!tail_phase && !calm && $urandom_range(0, 4) == 0)
                hold = $urandom_range(1, 17);
            m_tready <= (hold == 0);
            if ($urandom_range(0, 399) == 0)
                calm = !calm;
        end
    end

    // main stimulus
    initial
    begin
        int len;
        bit in_order;
        @(posedge rst_n);

        // coefficients still zero: logit zero gives one half, spread zero
        push_item(KIND_FEATURE, 4'd0, Q16_ONE, 1'b1);
        // win bias at -8.0 hits the bottom knot; feature past the weights adds nothing
        push_item(KIND_WIN_LOAD, BIAS_POS, MINUS_EIGHT, 1'b0);
        push_item(KIND_FEATURE, 4'd15, $urandom, 1'b1);
        // win bias at 8.0 clamps to the top knot
        push_item(KIND_WIN_LOAD, BIAS_POS, PLUS_EIGHT, 1'b0);
        push_item(KIND_FEATURE, BIAS_POS, $urandom, 1'b1);
        // one lsb under 8.0 interpolates in the last segment
        push_item(KIND_WIN_LOAD, BIAS_POS, PLUS_EIGHT - 1, 1'b0);
        push_item(KIND_FEATURE, 4'd3, Q16_ONE, 1'b1);
        // largest products push both sums into positive saturation
        push_item(KIND_WIN_LOAD, 4'd0, Q16_MAX, 1'b0);
        push_item(KIND_SPREAD_LOAD, 4'd0, Q16_MAX, 1'b0);
        repeat (2) push_item(KIND_FEATURE, 4'd0, Q16_MAX, 1'b0);
        push_item(KIND_FEATURE, 4'd0, Q16_MAX, 1'b1);
        // most negative feature pushes both sums into negative saturation
        repeat (2) push_item(KIND_FEATURE, 4'd0, Q16_MIN, 1'b0);
        push_item(KIND_FEATURE, 4'd0, Q16_MIN, 1'b1);
        // last flag on a load, reserved kind and loads past the bias are all ignored
        push_item(KIND_SPREAD_LOAD, BIAS_POS, Q16_MIN, 1'b1);
        push_item(KIND_RESERVED, 4'd5, '1, 1'b1);
        push_item(KIND_WIN_LOAD, 4'd13, '1, 1'b0);
        push_item(KIND_SPREAD_LOAD, 4'd15, '1, 1'b1);
        push_item(KIND_FEATURE, 4'd11, Q16_MIN, 1'b1);

        wait_drained();
        useful_items = 0;

        // random vectors, noise and broken vectors
        while (useful_items < RANDOM_ITEMS)
        begin
            if (useful_items >= RANDOM_ITEMS - TAIL_ITEMS)
                tail_phase = 1'b1;
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                7, 8:
                begin
                    repeat ($urandom_range(1, 4))
                        push_item(2'($urandom_range(KIND_WIN_LOAD, KIND_RESERVED)),
                                  POS_W'($urandom_range(0, 15)), $urandom,
                                  1'($urandom_range(0, 1)));
                end
                9:
                begin
                    repeat ($urandom_range(1, 4))
                        push_item(KIND_FEATURE, POS_W'($urandom_range(0, 15)),
                                  pick_value(), 1'b0);
                end
                default:
                begin
                    repeat ($urandom_range(0, 5))
                        push_item(2'($urandom_range(KIND_WIN_LOAD, KIND_SPREAD_LOAD)),
                                  POS_W'($urandom_range(0, FEATURES)), pick_value(),
                                  1'($urandom_range(0, 1)));
                    len      = $urandom_range(1, FEATURES);
                    in_order = 1'($urandom_range(0, 1));
                    for (int j = 0; j < len; j++)
                        push_item(KIND_FEATURE,
                                  in_order ? POS_W'(j)
                                           : POS_W'($urandom_range(0, FEATURES - 1)),
                                  pick_value(), j == len - 1);
                end
            endcase
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule
